[hdl/ops_pkg.sv]
package ops_pkg;

  localparam int CordicSteps = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [34:0] TravelLimit = 35'sd4294967296;

  typedef enum logic [1:0] {
    LEG_FIRST  = 2'd0,
    LEG_TURN   = 2'd1,
    LEG_SECOND = 2'd2,
    LEG_DONE   = 2'd3
  } leg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_DTH,
    ST_DTHH,
    ST_CORDIC,
    ST_PX,
    ST_PY,
    ST_SQX,
    ST_SQY,
    ST_SQL,
    ST_DECIDE,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_MPT    = 3'd0;
  localparam logic [2:0] REG_TPM    = 3'd1;
  localparam logic [2:0] REG_FIRST  = 3'd2;
  localparam logic [2:0] REG_TURN   = 3'd3;
  localparam logic [2:0] REG_SECOND = 3'd4;
  localparam logic [2:0] REG_FWD    = 3'd5;
  localparam logic [2:0] REG_SPIN   = 3'd6;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        5'd24: r = 32'd41;        5'd25: r = 32'd20;
        5'd26: r = 32'd10;        5'd27: r = 32'd5;
        5'd28: r = 32'd3;         5'd29: r = 32'd1;
        5'd30: r = 32'd1;         default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

[hdl/ops_cordic.sv]
// Rotation-mode CORDIC, one micro-rotation per cycle.
module ops_cordic import ops_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);

  logic               busy;
  logic [4:0]         step;
  logic [1:0]         quad;
  logic signed [33:0] x, y;
  logic signed [32:0] z;
  logic [1:0]         q_in;
  logic [31:0]        z_in;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;

  assign q_in = 2'((angle + 32'h2000_0000) >> 30);
  assign z_in = angle - {q_in, 30'd0};
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = {1'b0, atan_entry(step)};

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quad <= q_in;
        x    <= CordicGain;
        y    <= '0;
        z    <= {z_in[31], z_in};
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - ys; y <= y + xs; z <= z - at;
        end else begin
          x <= x + ys; y <= y - xs; z <= z + at;
        end
        if (step == 5'(CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end

  // quadrant fold
  always_comb begin
    unique case (quad)
      2'd0: begin cos_out = x;  sin_out = y;  end
      2'd1: begin cos_out = -y; sin_out = x;  end
      2'd2: begin cos_out = -x; sin_out = -y; end
      default: begin cos_out = y; sin_out = -x; end
    endcase
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("cordic done without run");

endmodule

[hdl/odometry_path_sequencer.sv]
// Differential-drive odometry with a three-leg path script.
// Input s_axis: tdata = {right_count, left_count}; one item per encoder tick.
// Output m_axis: one result per input item (motor commands, leg, pose).
// cfg: write channel, cfg_index selects register 0..6, others ignored.
// A shared 35x34 multiplier is sequenced over two distance products, two
// heading products, two projections and three squares; a 24-step CORDIC runs
// alongside from the second distance product on. A primed item runs all of
// these steps before its result is offered; the priming item goes straight
// to the three squares and the leg decision.
// s_axis_tready is high only while idle with no cfg write offered; the block
// stays busy until the result has been taken, so a stalled receiver holds the block.
// The first item after reset primes the stored counts and leaves the pose as it is.
// Reset (rst, synchronous) clears pose, marks, leg and restores registers.
module odometry_path_sequencer import ops_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // left_count, right_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [135:0] m_axis_tdata   // left_cmd, right_cmd, leg, pose_x, pose_y, heading
);

  logic [31:0] meters_per_tick, turn_per_meter;
  logic [30:0] first_leg, turn_angle, second_leg;
  logic [14:0] forward_speed, spin_speed;

  logic [31:0] prev_left, prev_right, heading, mark_heading;
  logic        primed;
  logic signed [31:0] pos_x, pos_y, mark_x, mark_y;
  leg_t        leg;
  state_t      state, state_next;

  logic [31:0] in_l, in_r;
  logic signed [32:0] dl, dr;
  logic signed [55:0] distl, distr;
  logic signed [34:0] dtrav;
  logic signed [33:0] cval, sval;
  logic [63:0] sq_x, sq_y;
  logic [55:0] th_lo;
  logic        sel_r;
  logic signed [15:0] lcmd, rcmd;

  // shared multiplier: 35 x 34 signed
  logic signed [34:0] ma;
  logic signed [33:0] mb;
  logic signed [68:0] mp;
  assign mp = ma * mb;

  logic        c_start, c_done;
  ops_cordic u_cordic (
    .clk, .rst, .start(c_start), .angle(heading),
    .done(c_done), .cos_out(cval), .sin_out(sval)
  );

  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign m_axis_tvalid = (state == ST_OUT);

  assign in_l = s_axis_tdata[31:0];
  assign in_r = s_axis_tdata[63:32];

  // squared distance operands
  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;
  assign dx = 33'(pos_x) - 33'(mark_x);
  assign dy = 33'(pos_y) - 33'(mark_y);
  assign ax = dx[32] ? 33'(-dx) : dx;
  assign ay = dy[32] ? 33'(-dy) : dy;
  logic [30:0] leg_len;
  assign leg_len = (leg == LEG_FIRST) ? first_leg : second_leg;

  // heading step for turn test
  logic [31:0] dh;
  logic [31:0] mag;
  assign dh = heading - mark_heading;
  assign mag = dh[31] ? (32'd0 - dh) : dh;

  logic signed [56:0] diff;
  assign diff = 57'(distr) - 57'(distl);

  // multiplier operand select
  always_comb begin
    ma = '0; mb = '0;
    unique case (state)
      ST_DIST: begin
        ma = sel_r ? 35'(dr) : 35'(dl);
        mb = {2'b0, meters_per_tick};
      end
      ST_DTH: begin ma = {7'b0, diff[27:0]}; mb = {2'b0, turn_per_meter}; end
      ST_DTHH: begin ma = {7'b0, diff[55:28]}; mb = {2'b0, turn_per_meter}; end
      ST_PX: begin ma = dtrav; mb = cval; end
      ST_PY: begin ma = dtrav; mb = sval; end
      ST_SQX: begin ma = {2'b0, ax}; mb = {1'b0, ax}; end
      ST_SQY: begin ma = {2'b0, ay}; mb = {1'b0, ay}; end
      ST_SQL: begin ma = {4'b0, leg_len}; mb = {3'b0, leg_len}; end
      default: ;
    endcase
  end

  // heading step, low 56 bits of the wheel difference times turn_per_meter
  logic [55:0] th_sum;
  assign th_sum = th_lo + {mp[27:0], 28'd0};

  logic signed [56:0] dsum;
  assign dsum = (57'(distl) + 57'(distr)) >>> 1;
  logic signed [34:0] incr;
  assign incr = 35'(mp >>> 30);
  logic signed [34:0] psum;
  assign psum = 35'(state == ST_PX ? pos_x : pos_y) + incr;
  logic signed [31:0] psat;
  assign psat = (psum > 35'sd2147483647) ? 32'sh7fffffff :
                (psum < -35'sd2147483648) ? 32'sh80000000 : psum[31:0];
  logic [64:0] sqsum;
  assign sqsum = {1'b0, sq_x} + {1'b0, sq_y};
  logic reach;
  assign reach = sqsum[64] || (sqsum[63:0] >= 64'(mp));

  // next state
  always_comb begin
    state_next = state;
    c_start = 1'b0;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready)
                 state_next = primed ? ST_DIST : ST_SQX;
      ST_DIST: if (sel_r) begin state_next = ST_DTH; c_start = 1'b1; end
      ST_DTH: state_next = ST_DTHH;
      ST_DTHH: state_next = ST_CORDIC;
      ST_CORDIC: if (c_done) state_next = ST_PX;
      ST_PX: state_next = ST_PY;
      ST_PY: state_next = ST_SQX;
      ST_SQX: state_next = ST_SQY;
      ST_SQY: state_next = ST_SQL;
      ST_SQL: state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      meters_per_tick <= 32'd2473724;
      turn_per_meter  <= 32'd3797584741;
      first_leg  <= 31'd8388608;
      turn_angle <= 31'd1073741824;
      second_leg <= 31'd4194304;
      forward_speed <= 15'd6554;
      spin_speed <= 15'd4915;
      prev_left <= '0; prev_right <= '0; primed <= 1'b0;
      pos_x <= '0; pos_y <= '0; heading <= '0;
      mark_x <= '0; mark_y <= '0; mark_heading <= '0;
      leg <= LEG_FIRST;
      sel_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MPT:    meters_per_tick <= cfg_data;
          REG_TPM:    turn_per_meter <= cfg_data;
          REG_FIRST:  first_leg <= cfg_data[30:0];
          REG_TURN:   turn_angle <= cfg_data[30:0];
          REG_SECOND: second_leg <= cfg_data[30:0];
          REG_FWD:    forward_speed <= cfg_data[14:0];
          REG_SPIN:   spin_speed <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          dl <= 33'($signed(in_l - prev_left));
          dr <= 33'($signed(in_r - prev_right));
          prev_left <= in_l; prev_right <= in_r;
          primed <= 1'b1;
          sel_r <= 1'b0;
        end
        ST_DIST: begin
          if (sel_r) distr <= 56'(mp >>> 8);
          else distl <= 56'(mp >>> 8);
          sel_r <= 1'b1;
        end
        ST_DTH: begin
          th_lo <= mp[55:0];
          dtrav <= (dsum > 57'(TravelLimit)) ? TravelLimit :
                   (dsum < -57'(TravelLimit)) ? -TravelLimit : 35'(dsum);
        end
        ST_DTHH: heading <= heading + th_sum[55:24];
        ST_PX: pos_x <= psat;
        ST_PY: pos_y <= psat;
        ST_SQX: sq_x <= 64'(mp);
        ST_SQY: sq_y <= 64'(mp);
        ST_SQL: begin
          lcmd <= '0; rcmd <= '0;
          unique case (leg)
            LEG_FIRST: if (reach) begin
              mark_heading <= heading; leg <= LEG_TURN;
            end else begin
              lcmd <= {1'b0, forward_speed}; rcmd <= {1'b0, forward_speed};
            end
            LEG_TURN: if (mag >= {1'b0, turn_angle}) begin
              mark_x <= pos_x; mark_y <= pos_y; leg <= LEG_SECOND;
            end else begin
              lcmd <= {1'b0, spin_speed}; rcmd <= -{1'b0, spin_speed};
            end
            LEG_SECOND: if (reach) leg <= LEG_DONE;
              else begin
                lcmd <= {1'b0, forward_speed}; rcmd <= {1'b0, forward_speed};
              end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, heading, pos_y, pos_x, leg, rcmd, lcmd};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && leg == LEG_DONE) |-> (lcmd == 16'sd0 && rcmd == 16'sd0))
    else $error("command in done leg");

endmodule

[tb/tb.sv]
`default_nettype none

module tb;
  import ops_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumDirected = 22;
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 116;
  localparam int SettleCycles = 60;

  // highest field first, matching the packing of m_axis_tdata
  typedef struct packed {
    logic [31:0]        heading;
    logic [31:0]        pose_y;
    logic [31:0]        pose_x;
    leg_t               leg;
    logic signed [15:0] right_cmd;
    logic signed [15:0] left_cmd;
  } drive_result_t;

  // arctangent steps of the CORDIC, binary angle units
  localparam longint AtanStep [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;      // left_count, right_count
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;          // left_cmd, right_cmd, leg, pose_x, pose_y, heading

  odometry_path_sequencer dut (.*);

  // shadow registers and pose of the tracker
  logic [31:0] trk_mpt, trk_tpm, trk_first, trk_turn, trk_second, trk_fwd, trk_spin;
  logic [31:0] trk_prev_l, trk_prev_r, trk_heading, trk_mark_hd;
  logic        trk_primed;
  longint      trk_x, trk_y, trk_mark_x, trk_mark_y;
  leg_t        trk_leg;

  drive_result_t pending_results [$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  longint unsigned cyc = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // rotation-mode CORDIC after folding to the nearest quarter turn
  function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                  output longint s);
    logic [31:0] t;
    logic [1:0] q;
    longint x, y, z, nx;
    t = ang + 32'h2000_0000;
    q = t[31:30];
    z = longint'($signed(ang - {q, 30'b0}));
    x = longint'(CordicGain);
    y = 0;
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - AtanStep[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + AtanStep[i];
      end
      x = nx;
    end
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic bit leg_covered(logic [31:0] len);
    longint ax, ay;
    logic [63:0] sx, sy, lim;
    logic [64:0] sum;
    ax = abs64(trk_x - trk_mark_x);
    ay = abs64(trk_y - trk_mark_y);
    sx = ax * ax;
    sy = ay * ay;
    lim = {32'b0, len} * {32'b0, len};
    sum = {1'b0, sx} + {1'b0, sy};
    return sum[64] || (sum[63:0] >= lim);
  endfunction

  // advance the pose and the path script by one encoder tick
  function automatic drive_result_t track_tick(logic [31:0] l, logic [31:0] r);
    drive_result_t res;
    longint dl, dr, distl, distr, d, c, s, dh;
    logic [63:0] dd, prod;
    int lc, rc;
    lc = 0;
    rc = 0;
    if (trk_primed) begin
      dl = longint'($signed(l - trk_prev_l));
      dr = longint'($signed(r - trk_prev_r));
      distl = (dl * longint'({32'b0, trk_mpt})) >>> 8;
      distr = (dr * longint'({32'b0, trk_mpt})) >>> 8;
      d = (distl + distr) >>> 1;
      dd = distr - distl;
      prod = dd * {32'b0, trk_tpm};
      if (d > 64'sd4294967296) d = 64'sd4294967296;
      if (d < -64'sd4294967296) d = -64'sd4294967296;
      sin_cos(trk_heading, c, s);
      trk_x = clamp32(trk_x + ((d * c) >>> 30));
      trk_y = clamp32(trk_y + ((d * s) >>> 30));
      trk_heading = trk_heading + prod[55:24];
    end
    trk_prev_l = l;
    trk_prev_r = r;
    trk_primed = 1'b1;
    case (trk_leg)
      LEG_FIRST: begin
        if (leg_covered(trk_first)) begin
          trk_mark_hd = trk_heading;
          trk_leg = LEG_TURN;
        end else begin
          lc = trk_fwd; rc = trk_fwd;
        end
      end
      LEG_TURN: begin
        dh = longint'($signed(trk_heading - trk_mark_hd));
        if (abs64(dh) >= longint'({32'b0, trk_turn})) begin
          trk_mark_x = trk_x;
          trk_mark_y = trk_y;
          trk_leg = LEG_SECOND;
        end else begin
          lc = trk_spin; rc = -trk_spin;
        end
      end
      LEG_SECOND: begin
        if (leg_covered(trk_second)) trk_leg = LEG_DONE;
        else begin
          lc = trk_fwd; rc = trk_fwd;
        end
      end
      default: ;
    endcase
    res.left_cmd = lc[15:0];
    res.right_cmd = rc[15:0];
    res.leg = trk_leg;
    res.pose_x = trk_x[31:0];
    res.pose_y = trk_y[31:0];
    res.heading = trk_heading;
    return res;
  endfunction

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // receiver: long ready stretches alternating with random stalls
  always @(posedge clk) begin
    if (cyc[8:6] == 3'd0 || cyc[8:6] == 3'd5) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    drive_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[129:0];
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.left_cmd !== want.left_cmd || got.right_cmd !== want.right_cmd ||
            got.leg !== want.leg || got.pose_x !== want.pose_x ||
            got.pose_y !== want.pose_y || got.heading !== want.heading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d differs: expected %p, got %p", checked, want, got);
        end
      end
    end
  end

  // valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      REG_MPT:    trk_mpt = val;
      REG_TPM:    trk_tpm = val;
      REG_FIRST:  trk_first = {1'b0, val[30:0]};
      REG_TURN:   trk_turn = {1'b0, val[30:0]};
      REG_SECOND: trk_second = {1'b0, val[30:0]};
      REG_FWD:    trk_fwd = {17'b0, val[14:0]};
      REG_SPIN:   trk_spin = {17'b0, val[14:0]};
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // sender works in bursts with random gaps between them
  task automatic send_tick(logic [31:0] l, logic [31:0] r, output drive_result_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, l};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    sent++;
    res = track_tick(l, r);
  endtask

  logic [31:0] dir_l [NumDirected] = '{
    32'd0, 32'd300, 32'd600, 32'd900, 32'd1200, 32'd1350, 32'd1500, 32'd1650,
    32'd1950, 32'd2250, 32'd2550, 32'd2850, 32'd3000,
    32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h5555_5555,
    32'haaaa_aaaa, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff
  };
  logic [31:0] dir_r [NumDirected] = '{
    32'd0, 32'd300, 32'd600, 32'd900, 32'd1200, 32'd1050, 32'd900, 32'd750,
    32'd1050, 32'd1350, 32'd1650, 32'd1950, 32'd2100,
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'haaaa_aaaa,
    32'h5555_5555, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000
  };

  initial begin
    drive_result_t res, first_exp;
    logic [31:0] cur_l, cur_r, v;
    int mode, k;
    trk_mpt = 32'd2473724; trk_tpm = 32'd3797584741; trk_first = 32'd8388608;
    trk_turn = 32'd1073741824; trk_second = 32'd4194304;
    trk_fwd = 32'd6554; trk_spin = 32'd4915;
    trk_prev_l = '0; trk_prev_r = '0; trk_heading = '0; trk_mark_hd = '0;
    trk_primed = 1'b0;
    trk_x = 0; trk_y = 0; trk_mark_x = 0; trk_mark_y = 0;
    trk_leg = LEG_FIRST;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk: priming, the three legs, a reverse spin, count extremes
    first_exp = '{left_cmd: 16'sd6554, right_cmd: 16'sd6554, leg: LEG_FIRST,
                  pose_x: '0, pose_y: '0, heading: '0};
    for (int i = 0; i < NumDirected; i++) begin
      send_tick(dir_l[i], dir_r[i], res);
      pending_results.push_back((i == 0) ? first_exp : res);
    end
    s_axis_tvalid <= 1'b0;
    cur_l = dir_l[NumDirected - 1];
    cur_r = dir_r[NumDirected - 1];

    // random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      for (int idx = 0; idx < 7; idx++) begin
        case (p)
          0: v = 32'hffff_ffff;
          1: v = 32'h0000_0000;
          2: v = (idx == 0) ? 32'd2473724 : $urandom;
          default: v = $urandom;
        endcase
        write_reg(idx[2:0], v);
      end
      write_reg(3'd7, $urandom);
      if (p == NumPhases - 1) write_reg(REG_MPT, $urandom_range(1, 32'h0100_0000));
      cfg_valid <= 1'b0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        mode = $urandom_range(0, 9);
        k = $urandom_range(0, 300);
        if (mode < 4) begin
          cur_l = cur_l + k; cur_r = cur_r + k + $urandom_range(0, 7);
        end else if (mode < 6) begin
          cur_l = cur_l + k; cur_r = cur_r - k;
        end else if (mode < 7) begin
          cur_l = cur_l - k; cur_r = cur_r - $urandom_range(0, 300);
        end else if (mode < 9) begin
          cur_l = cur_l + $urandom; cur_r = cur_r + $urandom;
        end else begin
          cur_l = $urandom; cur_r = $urandom;
        end
        send_tick(cur_l, cur_r, res);
        pending_results.push_back(res);
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    $display("covered %0d encoder ticks over %0d register settings (%0d writes)",
             sent, NumPhases + 1, cfg_writes);
    $display("%0d result items checked, %0d mismatches, final leg %s",
             checked, mismatches, trk_leg.name());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
